>>> hdl/btts_pkg.sv
package btts_pkg;

  localparam int unsigned MAX_FIELD_BYTES_DEF  = 255;
  localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned TAG_W  = 14;
  localparam int unsigned LEFT_W = 3;

  localparam logic [4:0] TAG_ESCAPE = 5'h1F;
  localparam logic [6:0] GROUP_MASK = 7'h7F;

  typedef enum logic [2:0] {
    PH_TAG0,
    PH_TAGN,
    PH_LEN0,
    PH_LENN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] value_offset;
    logic [7:0] value_length;
    logic       malformed;
  } out_item_t;

endpackage

>>> hdl/btts_parser.sv
module btts_parser #(
  parameter int unsigned MAX_FIELD_BYTES  = btts_pkg::MAX_FIELD_BYTES_DEF,
  parameter int unsigned MAX_LENGTH_BYTES = btts_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  btts_pkg::in_item_t            item,
  input  logic [btts_pkg::TAG_W-1:0]    target_tag,
  output logic                          result_valid,
  output btts_pkg::out_item_t           result
);

  import btts_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_FIELD_BYTES + 1);
  localparam int unsigned LEN_W = 8 * MAX_LENGTH_BYTES;

  phase_t            phase_r, phase_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [1:0]        tseen_r, tseen_nxt;
  logic [LEFT_W-1:0] lleft_r, lleft_nxt;
  logic [LEN_W-1:0]  lacc_r, lacc_nxt;
  logic [LEN_W-1:0]  skip_r, skip_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              mflag_r, mflag_nxt;
  logic [7:0]        moff_r, moff_nxt;
  logic [7:0]        mlen_r, mlen_nxt;
  logic              err_r, err_nxt;

  logic              hdr_done;
  logic [POS_W-1:0]  pos_cur;
  logic [POS_W:0]    off_w;
  logic [DATA_W-1:0] b;
  logic [6:0]        cnt;

  assign b   = item.data_byte;
  assign cnt = b[6:0];

  always_comb begin
    phase_nxt    = phase_r;
    tag_nxt      = tag_r;
    tseen_nxt    = tseen_r;
    lleft_nxt    = lleft_r;
    lacc_nxt     = lacc_r;
    skip_nxt     = skip_r;
    pos_nxt      = pos_r;
    mflag_nxt    = mflag_r;
    moff_nxt     = moff_r;
    mlen_nxt     = mlen_r;
    err_nxt      = err_r;
    hdr_done     = 1'b0;
    pos_cur      = pos_r;
    off_w        = '0;
    result_valid = 1'b0;
    result       = '0;

    if (item_valid) begin
      // restart the walk before this byte
      if (item.first_byte) begin
        phase_nxt = PH_TAG0;
        tag_nxt   = '0;
        tseen_nxt = '0;
        lleft_nxt = '0;
        lacc_nxt  = '0;
        skip_nxt  = '0;
        pos_nxt   = '0;
        mflag_nxt = 1'b0;
        moff_nxt  = '0;
        mlen_nxt  = '0;
        err_nxt   = 1'b0;
      end
      pos_cur = pos_nxt;

      if (phase_nxt != PH_DONE) begin
        if (pos_cur == POS_W'(MAX_FIELD_BYTES)) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          case (phase_nxt)
            PH_TAG0: begin
              tseen_nxt = 2'd1;
              if (b[4:0] != TAG_ESCAPE) begin
                tag_nxt   = TAG_W'(b[4:0]);
                phase_nxt = PH_LEN0;
              end else begin
                tag_nxt   = '0;
                phase_nxt = PH_TAGN;
              end
            end
            PH_TAGN: begin
              tag_nxt   = {tag_nxt[TAG_W-8:0], b[6:0] & GROUP_MASK};
              tseen_nxt = tseen_nxt + 2'd1;
              if (b[7]) begin
                if (tseen_nxt >= 2'd3 || tseen_nxt == 2'd0) begin
                  err_nxt   = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end else begin
                phase_nxt = PH_LEN0;
              end
            end
            PH_LEN0: begin
              if (!b[7]) begin
                lacc_nxt = LEN_W'(b);
                hdr_done = 1'b1;
              end else if (cnt == 7'd0 || 32'(cnt) > MAX_LENGTH_BYTES) begin
                err_nxt   = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                lleft_nxt = LEFT_W'(cnt);
                lacc_nxt  = '0;
                phase_nxt = PH_LENN;
              end
            end
            PH_LENN: begin
              lacc_nxt = LEN_W'({lacc_nxt, b});
              if (lleft_nxt != '0) begin
                lleft_nxt = lleft_nxt - 1'b1;
              end
              if (lleft_nxt == '0) begin
                hdr_done = 1'b1;
              end
            end
            PH_VALUE: begin
              if (skip_nxt != '0) begin
                skip_nxt = skip_nxt - 1'b1;
              end
              if (skip_nxt == '0) begin
                phase_nxt = mflag_nxt ? PH_DONE : PH_TAG0;
              end
            end
            default: begin
            end
          endcase

          // header complete: check the tag, then skip any value bytes
          if (hdr_done) begin
            if (tag_nxt == target_tag) begin
              off_w     = {1'b0, pos_cur} + 1'b1;
              mflag_nxt = 1'b1;
              moff_nxt  = (32'(off_w) > 32'd255) ? 8'hFF : 8'(off_w);
              mlen_nxt  = (32'(lacc_nxt) > 32'd255) ? 8'hFF : 8'(lacc_nxt);
            end
            skip_nxt = lacc_nxt;
            if (lacc_nxt != '0) begin
              phase_nxt = PH_VALUE;
            end else begin
              phase_nxt = mflag_nxt ? PH_DONE : PH_TAG0;
            end
          end
        end
      end

      if (pos_cur != POS_W'(MAX_FIELD_BYTES)) begin
        pos_nxt = pos_cur + 1'b1;
      end

      if (item.last_byte) begin
        if (phase_nxt == PH_TAGN || phase_nxt == PH_LEN0 ||
            phase_nxt == PH_LENN || phase_nxt == PH_VALUE) begin
          err_nxt = 1'b1;
        end
        result_valid        = 1'b1;
        result.found        = mflag_nxt;
        result.value_offset = mflag_nxt ? moff_nxt : 8'd0;
        result.value_length = mflag_nxt ? mlen_nxt : 8'd0;
        result.malformed    = err_nxt;
        phase_nxt = PH_TAG0;
        tag_nxt   = '0;
        tseen_nxt = '0;
        lleft_nxt = '0;
        lacc_nxt  = '0;
        skip_nxt  = '0;
        pos_nxt   = '0;
        mflag_nxt = 1'b0;
        moff_nxt  = '0;
        mlen_nxt  = '0;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG0;
      tag_r   <= '0;
      tseen_r <= '0;
      lleft_r <= '0;
      lacc_r  <= '0;
      skip_r  <= '0;
      pos_r   <= '0;
      mflag_r <= 1'b0;
      moff_r  <= '0;
      mlen_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      tseen_r <= tseen_nxt;
      lleft_r <= lleft_nxt;
      lacc_r  <= lacc_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      mflag_r <= mflag_nxt;
      moff_r  <= moff_nxt;
      mlen_r  <= mlen_nxt;
      err_r   <= err_nxt;
    end
  end

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    result_valid |=> (phase_r == PH_TAG0 && pos_r == '0 && !mflag_r && !err_r))
    else $error("parse state not cleared after a result");

  a_match_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mflag_r |-> (phase_r == PH_VALUE || phase_r == PH_DONE))
    else $error("match flagged while still walking headers");

  a_lenn_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LENN) |-> (lleft_r != '0))
    else $error("length bytes phase with nothing left to read");

  a_tag_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TAGN) |-> (tseen_r == 2'd1 || tseen_r == 2'd2))
    else $error("tag continuation with bad byte count");

endmodule

>>> hdl/ber_tlv_tag_search_unit.sv
// Channel  Handshake          Payload                  Direction
// in_      in_valid/in_stall  btts_pkg::in_item_t      into block, one byte per item
// out_     out_valid/out_stall btts_pkg::out_item_t    out of block, one item per field
// cfg_     cfg_valid/cfg_ready cfg_target_tag [13:0]   into block, target tag number
//
// One byte item is taken every cycle while in_stall is low; the per-byte parse step
// sits between the input register and the result register, so out_valid rises once
// the last byte of its field has left the input register and its result is registered.
// Reset is synchronous on rst_n low; it clears the parse state and the target tag.
// A last-byte item waits in the input register while an earlier result is held
// by out_stall; in_stall rises only then.
module ber_tlv_tag_search_unit #(
  parameter int unsigned MAX_FIELD_BYTES  = btts_pkg::MAX_FIELD_BYTES_DEF,
  parameter int unsigned MAX_LENGTH_BYTES = btts_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  btts_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output btts_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [btts_pkg::TAG_W-1:0] cfg_target_tag
);

  import btts_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  in_item_t         s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;
  logic [TAG_W-1:0] target_r;

  logic             out_free;
  logic             advance;
  logic             in_accept;
  logic             res_valid;
  out_item_t        res_item;

  assign out_free  = !out_valid_r || !out_stall;
  // only a last byte needs room in the result register
  assign advance   = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = res_valid ? 1'b1 : (out_valid_r && out_stall);

  btts_parser #(
    .MAX_FIELD_BYTES  (MAX_FIELD_BYTES),
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (advance),
    .item         (s1_item_r),
    .target_tag   (target_r),
    .result_valid (res_valid),
    .result       (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_target_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_item_r.last_byte && out_valid_r && out_stall))
    else $error("input stalled without a held result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !res_valid)
    else $error("result produced while result register is held");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (advance && s1_item_r.last_byte))
    else $error("result without a last byte");

endmodule
